// ===== rtl/lrqs_pkg.sv =====
// Package with payload types and fixed field widths for the lottery ready queue scheduler.
`default_nettype none
package lrqs_pkg;

    localparam int unsigned CMD_W     = 1;
    localparam int unsigned PID_W     = 8;
    localparam int unsigned RND_W     = 31;
    localparam int unsigned QUANTUM_W = 16;
    localparam int unsigned TICKET_W  = 12;
    localparam int unsigned COUNT_W   = 5;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_SELECT  = 1'b1;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PID_W-1:0] process_id;
        logic [RND_W-1:0] random_value;
    } t_in_word;

    typedef struct packed {
        logic                 found;
        logic [PID_W-1:0]     winner_id;
        logic [QUANTUM_W-1:0] quantum_load;
        logic [TICKET_W-1:0]  draw_ticket;
        logic                 overflow;
        logic [COUNT_W-1:0]   queue_count;
    } t_out_word;

endpackage
`default_nettype wire

// ===== rtl/lrqs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lrqs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/lottery_ready_queue_scheduler_unit.sv =====
// Top level of the lottery ready queue scheduler: queue memory, modulo unit and control.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------
//  input   | in        | i_valid / o_stall   | i_in  (t_in_word)
//  output  | out       | o_valid / i_stall   | o_out (t_out_word)
//  config  | in        | i_cfg_we            | i_cfg_wdata (quantum)
//
// An enqueue result is valid the cycle after the word is accepted. A select on
// N queued ids runs in steps: one memory pass sums the tickets, a restoring
// divider yields one remainder bit per cycle, a second pass walks the sums up
// to the winner, and a third shifts later entries down one per cycle through
// the single read port of the queue RAM. Reset is synchronous and needs no
// clearing pass. One word is worked at a time; a result held by a stalled
// receiver keeps the input stalled until it leaves.
`default_nettype none
module lottery_ready_queue_scheduler_unit #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire lrqs_pkg::t_in_word         i_in,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output lrqs_pkg::t_out_word             o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [lrqs_pkg::QUANTUM_W-1:0] i_cfg_wdata
);
    import lrqs_pkg::*;

    localparam int unsigned ID_WIDTH   = PID_W;
    localparam int unsigned RAND_WIDTH = RND_W;
    localparam int unsigned AW  = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
    // Total tickets reach QUEUE_DEPTH * 2^ID_WIDTH.
    localparam int unsigned SW  = ID_WIDTH + CW;
    localparam int unsigned BW  = $clog2(RAND_WIDTH + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SUM   = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_WALK  = 4'd3;
    localparam logic [3:0] ST_SHIFT = 4'd4;
    localparam logic [3:0] ST_DONE  = 4'd5;

    logic [3:0]             r_state;
    logic [CW-1:0]          r_total;
    logic [QUANTUM_W-1:0]   r_quantum;
    logic [RAND_WIDTH-1:0]  r_rnd;
    logic [CW-1:0]          r_idx;       // address issued this cycle
    logic                   r_rvld;      // read data valid this cycle
    logic [SW-1:0]          r_sum;
    logic [SW-1:0]          r_tickets;
    logic [SW-1:0]          r_rem;
    logic [BW-1:0]          r_bit;
    logic [ID_WIDTH-1:0]    r_winner;
    logic                   r_found;
    logic                   r_out_vld;
    t_out_word              r_out;
    t_out_word              n_enq_out;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ID_WIDTH-1:0]    ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [ID_WIDTH-1:0]    ram_rdata;
    logic [SW-1:0]          rd_tickets;
    logic [SW:0]            rem_shift;
    logic [SW-1:0]          sum_next;
    logic                   accept;
    logic                   out_load;

    lrqs_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_ids (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Input handshake: take a word only when idle and the output slot is free.
    assign o_stall = (r_state != ST_IDLE) || (r_out_vld && i_stall);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_vld;
    assign o_out   = r_out;

    assign rd_tickets = SW'(ram_rdata) + SW'(1);
    assign sum_next   = r_sum + rd_tickets;
    assign rem_shift  = {r_rem, r_rnd[RAND_WIDTH-1]};

    // A result word is loaded for enqueues, empty selects and finished selects.
    assign out_load = (r_state == ST_IDLE && accept &&
                       (i_in.cmd == CMD_ENQUEUE || r_total == '0)) ||
                      (r_state == ST_DONE && (!r_out_vld || !i_stall));

    // Result word of an enqueue.
    always_comb begin
        n_enq_out = '0;
        if (r_total < CW'(QUEUE_DEPTH)) begin
            n_enq_out.queue_count = COUNT_W'(r_total + CW'(1));
        end else begin
            n_enq_out.overflow    = 1'b1;
            n_enq_out.queue_count = COUNT_W'(r_total);
        end
    end

    // Memory port control: write on enqueue or shift, read the walk index.
    // While idle the head entry is read so a select starts its sum pass at once.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_total[AW-1:0];
        ram_wdata = i_in.process_id[ID_WIDTH-1:0];
        ram_raddr = (r_state == ST_IDLE) ? '0 : r_idx[AW-1:0];
        if (accept && i_in.cmd == CMD_ENQUEUE && r_total < CW'(QUEUE_DEPTH)) begin
            ram_we = 1'b1;
        end else if (r_state == ST_SHIFT && r_rvld) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(r_idx - CW'(2));
            ram_wdata = ram_rdata;
        end
    end

    // Sequencer for select words and result formation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_total   <= '0;
            r_quantum <= QUANTUM_RESET;
            r_out_vld <= 1'b0;
            r_rvld    <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_rnd <= i_in.random_value[RAND_WIDTH-1:0];
                        if (i_in.cmd == CMD_ENQUEUE) begin
                            r_out <= n_enq_out;
                            if (r_total < CW'(QUEUE_DEPTH)) begin
                                r_total <= r_total + CW'(1);
                            end
                        end else if (r_total == '0) begin
                            r_out <= '0;
                        end else begin
                            r_state <= ST_SUM;
                            r_sum   <= '0;
                            r_idx   <= CW'(1);
                            r_rvld  <= 1'b1;
                        end
                    end
                end
                ST_SUM: begin
                    // Read data for entry r_idx-1 is present.
                    r_sum  <= sum_next;
                    r_idx  <= r_idx + CW'(1);
                    if (r_idx == r_total) begin
                        r_tickets <= sum_next;
                        r_rem     <= '0;
                        r_bit     <= BW'(RAND_WIDTH);
                        r_rvld    <= 1'b0;
                        r_state   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // Restoring remainder: one random bit per cycle.
                    if (rem_shift >= {1'b0, r_tickets}) begin
                        r_rem <= SW'(rem_shift - {1'b0, r_tickets});
                    end else begin
                        r_rem <= SW'(rem_shift);
                    end
                    r_rnd <= r_rnd << 1;
                    r_bit <= r_bit - BW'(1);
                    if (r_bit == BW'(1)) begin
                        r_state <= ST_WALK;
                        r_sum   <= '0;
                        r_idx   <= '0;
                    end
                end
                ST_WALK: begin
                    // First cycle issues address 0; then one entry per cycle.
                    r_idx <= r_idx + CW'(1);
                    if (r_rvld) begin
                        r_sum <= sum_next;
                    end
                    if (r_rvld && sum_next > r_rem) begin
                        r_winner <= ram_rdata;
                        r_found  <= 1'b1;
                        // The entry after the winner is being read; it is valid
                        // only when it lies inside the queue.
                        r_rvld   <= (r_idx < r_total);
                        r_state  <= ST_SHIFT;
                    end else begin
                        r_rvld <= 1'b1;
                    end
                end
                ST_SHIFT: begin
                    // Read at r_idx issued; data for r_idx-1 lands at r_idx-2.
                    if (r_idx < r_total) begin
                        r_idx  <= r_idx + CW'(1);
                        r_rvld <= 1'b1;
                    end else begin
                        r_rvld <= 1'b0;
                        if (!r_rvld || r_idx == r_total) begin
                            r_state <= ST_DONE;
                        end
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_DONE: begin
                    if (!r_out_vld || !i_stall) begin
                        r_total              <= r_total - CW'(1);
                        r_out.found          <= r_found;
                        r_out.winner_id      <= PID_W'(r_winner);
                        r_out.quantum_load   <= r_quantum;
                        r_out.draw_ticket    <= TICKET_W'(r_rem);
                        r_out.overflow       <= 1'b0;
                        r_out.queue_count    <= COUNT_W'(r_total - CW'(1));
                        r_rvld               <= 1'b0;
                        r_state              <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // The queue never holds more ids than it has room for.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // A select in progress always has a non-empty queue.
    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_total != '0))
        else $error("select running on empty queue");

    // The remainder stays below the ticket total once walking.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_rem < r_tickets))
        else $error("draw not reduced below ticket total");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the lottery ready queue scheduler unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import lrqs_pkg::*;

    localparam int QDEPTH = 16;
    localparam int N_RANDOM = 600;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    t_in_word        i_in;
    logic            o_valid;
    logic            i_stall;
    t_out_word       o_out;
    logic            i_cfg_we;
    logic [QUANTUM_W-1:0] i_cfg_wdata;

    lottery_ready_queue_scheduler_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_in(i_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // Shadow copy of the scheduler state.
    logic [PID_W-1:0]     shadow_ids [QDEPTH];
    int                   shadow_total;
    logic [QUANTUM_W-1:0] shadow_quantum;

    t_out_word pending_results[$];
    int        error_count;
    int        result_count;
    int        select_count;
    int        overflow_count;
    bit        hold_receiver;

    // Directed table: words plus typed-in expectations where they are obvious.
    typedef struct {
        t_in_word  word;
        bit        has_typed;
        t_out_word typed;
    } t_row;
    t_row directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Timeout waiting for scheduler results");
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Lottery draw on the shadow queue; returns the result the block must give.
    function automatic t_out_word schedule_word(input t_in_word w);
        t_out_word r;
        int unsigned tickets;
        int unsigned draw;
        int unsigned running;
        r = '0;
        if (w.cmd == CMD_ENQUEUE) begin
            if (shadow_total >= QDEPTH) begin
                r.overflow = 1'b1;
            end else begin
                shadow_ids[shadow_total] = w.process_id;
                shadow_total++;
            end
        end else if (shadow_total > 0) begin
            tickets = 0;
            for (int i = 0; i < shadow_total; i++) tickets += shadow_ids[i] + 1;
            draw = w.random_value % tickets;
            r.draw_ticket = draw[TICKET_W-1:0];
            running = 0;
            for (int i = 0; i < shadow_total; i++) begin
                running += shadow_ids[i] + 1;
                if (running > draw) begin
                    r.found = 1'b1;
                    r.winner_id = shadow_ids[i];
                    r.quantum_load = shadow_quantum;
                    for (int j = i; j + 1 < shadow_total; j++) shadow_ids[j] = shadow_ids[j + 1];
                    shadow_total--;
                    break;
                end
            end
        end
        r.queue_count = COUNT_W'(shadow_total);
        return r;
    endfunction

    function automatic t_in_word make_word(input logic c, input logic [PID_W-1:0] p,
                                           input logic [RND_W-1:0] v);
        t_in_word w;
        w.cmd = c;
        w.process_id = p;
        w.random_value = v;
        return w;
    endfunction

    function automatic t_out_word make_result(input logic f, input logic [PID_W-1:0] id,
                                              input logic [QUANTUM_W-1:0] q,
                                              input logic [TICKET_W-1:0] t,
                                              input logic o, input logic [COUNT_W-1:0] n);
        t_out_word r;
        r.found = f;
        r.winner_id = id;
        r.quantum_load = q;
        r.draw_ticket = t;
        r.overflow = o;
        r.queue_count = n;
        return r;
    endfunction

    task automatic add_row(input t_in_word w, input bit typed, input t_out_word r);
        t_row row;
        row.word = w;
        row.has_typed = typed;
        row.typed = r;
        directed_rows.push_back(row);
    endtask

    // Random gap length: mostly short, sometimes long.
    function automatic int gap_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one word and wait for its acceptance; predict on acceptance.
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word r);
        t_out_word predicted;
        i_valid <= 1'b1;
        i_in <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = schedule_word(w);
        if (typed && predicted != r) begin
            report_mismatch("typed row vs shadow", 32'(predicted), 32'(r));
        end
        pending_results.push_back(typed ? r : predicted);
        if (w.cmd == CMD_SELECT) select_count++;
    endtask

    task automatic send_with_gap(input t_in_word w);
        int g;
        send_word(w, 1'b0, '0);
        g = gap_cycles();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // Allow a final select walk to settle before touching the register.
        repeat (3 * QDEPTH + RND_W + 10) @(posedge i_clk);
    endtask

    task automatic write_quantum(input logic [QUANTUM_W-1:0] q);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= q;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_quantum = q;
    endtask

    // Receiver: compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_out.queue_count), 32'd0);
            end else begin
                t_out_word want;
                want = pending_results.pop_front();
                result_count++;
                if (o_out.overflow) overflow_count++;
                if (o_out.found !== want.found)
                    report_mismatch("found", 32'(o_out.found), 32'(want.found));
                if (o_out.winner_id !== want.winner_id)
                    report_mismatch("winner_id", 32'(o_out.winner_id), 32'(want.winner_id));
                if (o_out.quantum_load !== want.quantum_load)
                    report_mismatch("quantum_load", 32'(o_out.quantum_load),
                                    32'(want.quantum_load));
                if (o_out.draw_ticket !== want.draw_ticket)
                    report_mismatch("draw_ticket", 32'(o_out.draw_ticket),
                                    32'(want.draw_ticket));
                if (o_out.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(o_out.overflow), 32'(want.overflow));
                if (o_out.queue_count !== want.queue_count)
                    report_mismatch("queue_count", 32'(o_out.queue_count),
                                    32'(want.queue_count));
            end
        end
    end

    // Receiver stall pattern; a long hold-off when requested.
    initial begin
        int g;
        i_stall = 1'b0;
        forever begin
            if (hold_receiver) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_receiver = 1'b0;
            end
            g = gap_cycles();
            i_stall <= (g > 0);
            repeat (g > 0 ? g : $urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Main sequence.
    initial begin
        t_in_word w;
        int phase_items;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        error_count = 0;
        result_count = 0;
        select_count = 0;
        overflow_count = 0;
        hold_receiver = 1'b0;
        shadow_total = 0;
        shadow_quantum = QUANTUM_RESET;
        foreach (shadow_ids[i]) shadow_ids[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset quantum.
        add_row(make_word(CMD_SELECT, 8'hFF, 31'h7FFF_FFFF), 1'b1,
                make_result(1'b0, 8'd0, 16'd0, 12'd0, 1'b0, 5'd0));
        add_row(make_word(CMD_ENQUEUE, 8'h00, 31'h7FFF_FFFF), 1'b1,
                make_result(1'b0, 8'd0, 16'd0, 12'd0, 1'b0, 5'd1));
        add_row(make_word(CMD_SELECT, 8'hFF, 31'h7FFF_FFFF), 1'b1,
                make_result(1'b1, 8'd0, QUANTUM_RESET, 12'd0, 1'b0, 5'd0));
        add_row(make_word(CMD_ENQUEUE, 8'hFF, 31'h0), 1'b1,
                make_result(1'b0, 8'd0, 16'd0, 12'd0, 1'b0, 5'd1));
        add_row(make_word(CMD_SELECT, 8'h00, 31'h0), 1'b1,
                make_result(1'b1, 8'hFF, QUANTUM_RESET, 12'd0, 1'b0, 5'd0));
        for (int i = 0; i < QDEPTH; i++)
            add_row(make_word(CMD_ENQUEUE, (i % 2) ? 8'hFF : 8'(i * 17), 31'(i)), 1'b0, '0);
        add_row(make_word(CMD_ENQUEUE, 8'hAA, 31'h5555_5555), 1'b1,
                make_result(1'b0, 8'd0, 16'd0, 12'd0, 1'b1, 5'd16));
        add_row(make_word(CMD_SELECT, 8'h55, 31'h7FFF_FFFF), 1'b0, '0);
        add_row(make_word(CMD_SELECT, 8'h00, 31'h2AAA_AAAA), 1'b0, '0);
        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].has_typed, directed_rows[i].typed);
        drain_results();

        // Random phases across quantum settings, extremes included.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_quantum(16'hFFFF);
                1: write_quantum(16'h0000);
                2: write_quantum(16'h0001);
                default: write_quantum(16'($urandom_range(0, 65535)));
            endcase
            phase_items = N_RANDOM / 5;
            for (int k = 0; k < phase_items; k++) begin
                // Lean towards enqueue when short and select when full.
                if ($urandom_range(0, 15) >= shadow_total + 2 || $urandom_range(0, 9) == 0)
                    w = make_word(CMD_ENQUEUE, 8'($urandom_range(0, 255)), 31'($urandom));
                else
                    w = make_word(CMD_SELECT, 8'($urandom_range(0, 255)), 31'($urandom));
                if (phase == 2 && k == 20) hold_receiver = 1'b1;
                send_with_gap(w);
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        $display("Covered %0d results, %0d selects, %0d overflows, five quantum settings.",
                 result_count, select_count, overflow_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
